// ===== hw/rtl/wav_header_parse_check_macros.svh =====
// Assertion macros for the self-checking top block
`ifndef WAV_HEADER_PARSE_CHECK_MACROS_SVH
`define WAV_HEADER_PARSE_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WHPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define WHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/whpc_pkg.sv =====
package whpc_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 44;
    localparam int POS_W        = 6;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);

    // Default clip list depth
    localparam int MAX_CLIPS_DEF = 16;

    // Chunk tags, first character in the top byte
    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    // Expected format values
    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] CHAN_MONO = 16'h0001;
    localparam logic [15:0] BITS_16   = 16'h0010;

    // Four-byte groups of the header, indexed by position bits [5:2]
    typedef enum logic [3:0] {
        GRP_RIFF    = 4'd0,
        GRP_WAVE    = 4'd2,
        GRP_FMT_TAG = 4'd3,
        GRP_FORMAT  = 4'd5,
        GRP_RATE    = 4'd6,
        GRP_BITS    = 4'd8,
        GRP_DATA    = 4'd9,
        GRP_LENGTH  = 4'd10
    } group_t;

    // Tag flag bits
    localparam int FLAG_RIFF = 0;
    localparam int FLAG_WAVE = 1;
    localparam int FLAG_FMT  = 2;
    localparam int FLAG_DATA = 3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RIFF_WAVE = 3'd1,
        ST_FMT_DATA  = 3'd2,
        ST_FORMAT    = 3'd3,
        ST_BITS      = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef logic [3:0] slot_t;

    // Gathered header view handed from capture to result stage
    typedef struct packed {
        logic        first;
        logic        last;
        logic        tags_rw_ok;
        logic        tags_fd_ok;
        logic [15:0] fmt_tag;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [23:0] length_lo;
        logic [31:0] address;
        logic        ctype;
    } hdr_info_t;

    // Character i of a tag, file order
    function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
        return tag[{~idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/whpc_if.sv =====
// Header byte channel
interface whpc_byte_if;
    import whpc_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  header_byte;
    logic [31:0] clip_address;
    logic        clip_type;
    logic        start_new_list;

    modport source (output valid, header_byte, clip_address, clip_type, start_new_list,
                    input ready);
    modport sink   (input valid, header_byte, clip_address, clip_type, start_new_list,
                    output ready);
endinterface

// Parse result channel
interface whpc_result_if;
    import whpc_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    slot_t       slot;
    logic [31:0] data_address;
    logic [31:0] data_length;
    logic [31:0] sample_rate;
    logic        result_type;

    modport source (output valid, status, slot, data_address, data_length, sample_rate,
                    result_type, input ready);
    modport sink   (input valid, status, slot, data_address, data_length, sample_rate,
                    result_type, output ready);
endinterface

// ===== hw/rtl/whpc_capture.sv =====
module whpc_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          header_byte,
    input  logic [31:0]         clip_address,
    input  logic                clip_type,
    output whpc_pkg::hdr_info_t info
);
    import whpc_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [3:0]       flags_reg, flags_next;
    logic [15:0]      fmt_reg,   fmt_next;
    logic [15:0]      chans_reg, chans_next;
    logic [15:0]      bits_reg,  bits_next;
    logic [31:0]      rate_reg,  rate_next;
    logic [23:0]      len_reg,   len_next;
    logic [31:0]      addr_reg,  addr_next;
    logic             type_reg,  type_next;

    logic       first;
    logic       last;
    logic [3:0] grp;
    logic [1:0] lane;

    assign first = (pos_reg == '0);
    assign last  = (pos_reg == LAST_POS);
    assign grp   = pos_reg[5:2];
    assign lane  = pos_reg[1:0];

    // Per-byte position, tag check and field capture
    always_comb
    begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        fmt_next   = fmt_reg;
        chans_next = chans_reg;
        bits_next  = bits_reg;
        rate_next  = rate_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        type_next  = type_reg;
        if (fire)
        begin
            pos_next = last ? '0 : pos_reg + 1'b1;
            // first byte starts a fresh header
            if (first)
            begin
                flags_next = '1;
                fmt_next   = '0;
                chans_next = '0;
                bits_next  = '0;
                rate_next  = '0;
                len_next   = '0;
                addr_next  = clip_address;
                type_next  = clip_type;
            end
            case (grp)
                GRP_RIFF:
                begin
                    if (header_byte != tag_byte(TAG_RIFF, lane))
                        flags_next[FLAG_RIFF] = 1'b0;
                end
                GRP_WAVE:
                begin
                    if (header_byte != tag_byte(TAG_WAVE, lane))
                        flags_next[FLAG_WAVE] = 1'b0;
                end
                GRP_FMT_TAG:
                begin
                    if (header_byte != tag_byte(TAG_FMT, lane))
                        flags_next[FLAG_FMT] = 1'b0;
                end
                GRP_DATA:
                begin
                    if (header_byte != tag_byte(TAG_DATA, lane))
                        flags_next[FLAG_DATA] = 1'b0;
                end
                GRP_FORMAT:
                begin
                    if (!lane[1])
                        fmt_next[{lane[0], 3'b000} +: 8] = header_byte;
                    else
                        chans_next[{lane[0], 3'b000} +: 8] = header_byte;
                end
                GRP_RATE:
                begin
                    rate_next[{lane, 3'b000} +: 8] = header_byte;
                end
                GRP_BITS:
                begin
                    if (lane[1])
                        bits_next[{lane[0], 3'b000} +: 8] = header_byte;
                end
                GRP_LENGTH:
                begin
                    // top byte goes straight to the result stage
                    case (lane)
                        2'd0:    len_next[7:0]   = header_byte;
                        2'd1:    len_next[15:8]  = header_byte;
                        2'd2:    len_next[23:16] = header_byte;
                        default: len_next        = len_reg;
                    endcase
                end
                default:
                begin
                    pos_next = pos_next;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '1;
        end
        else
        begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
    end

    // Gathered fields
    always_ff @(posedge clk)
    begin
        fmt_reg   <= fmt_next;
        chans_reg <= chans_next;
        bits_reg  <= bits_next;
        rate_reg  <= rate_next;
        len_reg   <= len_next;
        addr_reg  <= addr_next;
        type_reg  <= type_next;
    end

    always_comb
    begin
        info.first      = first;
        info.last       = last;
        info.tags_rw_ok = flags_reg[FLAG_RIFF] & flags_reg[FLAG_WAVE];
        info.tags_fd_ok = flags_reg[FLAG_FMT] & flags_reg[FLAG_DATA];
        info.fmt_tag    = fmt_reg;
        info.chans      = chans_reg;
        info.bits       = bits_reg;
        info.rate       = rate_reg;
        info.length_lo  = len_reg;
        info.address    = addr_reg;
        info.ctype      = type_reg;
    end

endmodule

// ===== hw/rtl/whpc_result.sv =====
module whpc_result #(
    parameter int MAX_CLIPS = whpc_pkg::MAX_CLIPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                start_new_list,
    input  logic [7:0]          header_byte,
    input  whpc_pkg::hdr_info_t info,
    input  logic                out_ready,
    output logic                out_valid,
    output whpc_pkg::status_t   status,
    output whpc_pkg::slot_t     slot,
    output logic [31:0]         data_address,
    output logic [31:0]         data_length,
    output logic [31:0]         sample_rate,
    output logic                result_type
);
    import whpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_CLIPS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             valid_reg, valid_next;
    status_t          status_reg, status_next;
    slot_t            slot_reg,   slot_next;
    logic [31:0]      addr_reg,   len_reg, rate_reg;
    logic             type_reg;

    logic load;
    logic full;

    assign load = fire & info.last;
    assign full = (count_reg >= CNT_W'(MAX_CLIPS));

    // Check order and slot allocation
    always_comb
    begin
        slot_next = slot_t'(count_reg);
        if (full)
        begin
            status_next = ST_FULL;
            slot_next   = '0;
        end
        else if (!info.tags_rw_ok)
            status_next = ST_RIFF_WAVE;
        else if (!info.tags_fd_ok)
            status_next = ST_FMT_DATA;
        else if (info.fmt_tag != FMT_PCM || info.chans != CHAN_MONO)
            status_next = ST_FORMAT;
        else if (info.bits != BITS_16)
            status_next = ST_BITS;
        else
            status_next = ST_OK;
    end

    // Clip count: cleared on a new list, advanced per slot taken
    always_comb
    begin
        count_next = count_reg;
        if (fire && info.first && start_new_list)
            count_next = '0;
        else if (load && !full)
            count_next = count_reg + 1'b1;
    end

    assign valid_next = load | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            addr_reg   <= info.address + 32'(HEADER_BYTES);
            len_reg    <= {header_byte, info.length_lo};
            rate_reg   <= info.rate;
            type_reg   <= info.ctype;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign data_address = addr_reg;
    assign data_length  = len_reg;
    assign sample_rate  = rate_reg;
    assign result_type  = type_reg;

endmodule

// ===== hw/rtl/wav_header_parse_check.sv =====
// Channel   Role    Payload
// header    sink    header_byte, clip_address, clip_type, start_new_list
// result    source  status, slot, data_address, data_length, sample_rate, result_type
//
// One header byte is taken per cycle; a header of 44 bytes takes 44 transfers.
// The result appears in the output register in the cycle after the 44th byte.
// Reset clears the byte position, clip count and output valid, and sets the tag flags.
// Only the 44th byte waits on a stalled result; other bytes keep flowing.
module wav_header_parse_check #(
    parameter int MAX_CLIPS = whpc_pkg::MAX_CLIPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    whpc_byte_if.sink     header,
    whpc_result_if.source result
);
    import whpc_pkg::*;

    `include "wav_header_parse_check_macros.svh"

    hdr_info_t info;
    logic      fire;
    logic      res_valid;

    // Only the final byte needs room in the result register
    assign header.ready = ~info.last | ~res_valid | result.ready;
    assign fire         = header.valid & header.ready;
    assign result.valid = res_valid;

    whpc_capture u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .header_byte  (header.header_byte),
        .clip_address (header.clip_address),
        .clip_type    (header.clip_type),
        .info         (info)
    );

    whpc_result #(
        .MAX_CLIPS (MAX_CLIPS)
    ) u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .start_new_list (header.start_new_list),
        .header_byte    (header.header_byte),
        .info           (info),
        .out_ready      (result.ready),
        .out_valid      (res_valid),
        .status         (result.status),
        .slot           (result.slot),
        .data_address   (result.data_address),
        .data_length    (result.data_length),
        .sample_rate    (result.sample_rate),
        .result_type    (result.result_type)
    );

    // Self checks
    `WHPC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, fire && info.last, result.valid)
    `WHPC_ASSERT_NOW(a_full_slot_zero, clk, rst_n,
        result.valid && result.status == ST_FULL, result.slot == '0)
    `WHPC_ASSERT_NOW(a_stall_only_last, clk, rst_n, !header.ready,
        info.last && result.valid && !result.ready)
    `WHPC_ASSERT_NEXT(a_first_advances, clk, rst_n, fire && info.first, !info.first)

endmodule
